### design/lmn_pkg.sv
package lmn_pkg;

    localparam int DEF_MAX_NODES = 16;

    localparam logic [31:0] CLOCK_MAX   = 32'hFFFF_FFFF;
    localparam logic [3:0]  REPLY_MAX   = 4'd15;
    localparam logic [4:0]  RST_OWN_ID  = 5'd1;
    localparam logic [4:0]  RST_PCOUNT  = 5'd2;
    localparam logic [31:0] RST_CLOCK   = 32'd0;

    localparam logic [2:0] CMD_RECV_REQ  = 3'd0;
    localparam logic [2:0] CMD_RECV_REP  = 3'd1;
    localparam logic [2:0] CMD_RECV_REL  = 3'd2;
    localparam logic [2:0] CMD_TICK      = 3'd3;
    localparam logic [2:0] CMD_LOCAL_REQ = 3'd4;
    localparam logic [2:0] CMD_LOCAL_EXIT = 3'd5;

    localparam logic [1:0] MSG_REQUEST = 2'd0;
    localparam logic [1:0] MSG_REPLY   = 2'd1;
    localparam logic [1:0] MSG_RELEASE = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NO_GRANT  = 2'd2;

    localparam logic [1:0] CFG_OWN_ID      = 2'd0;
    localparam logic [1:0] CFG_PROC_COUNT  = 2'd1;
    localparam logic [1:0] CFG_START_CLOCK = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [4:0]  node;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic        ins;
        logic        rem;
        logic [4:0]  node;
        logic [31:0] stamp;
    } t_tbl_op;

    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  sender_id;
        logic [31:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic        msg_valid;
        logic [1:0]  msg_type;
        logic [4:0]  msg_destination;
        logic [31:0] msg_timestamp;
        logic        granted;
        logic [31:0] clock_now;
        logic [3:0]  replies_seen;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CLOCK_MAX) ? CLOCK_MAX : v + 32'd1;
    endfunction

endpackage

### design/lamport_mutex_node.sv
// One node of Lamport's distributed mutual exclusion. Items enter on the in
// channel, configuration on the cfg channel (always ready; write only while idle).
// The request table is a sorted row of MAX_NODES cells that shift together on
// insert or remove. An item is taken in the idle state, then passes the table
// states (remove, then insert and state update), then emits its results in turn
// (one per outgoing message, or one if none), stepping over the own id when a
// broadcast reaches it; output stalls hold the emission. The next item is taken
// in the cycle after the last result has moved into the output register.
module lamport_mutex_node #(
    parameter int MAX_NODES = lmn_pkg::DEF_MAX_NODES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lmn_pkg::t_in_item  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lmn_pkg::t_out_item o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int NW = $clog2(MAX_NODES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REM  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_own_id, n_own_id;
    logic [4:0]  r_pc, n_pc;
    logic [31:0] r_clock, n_clock;
    logic [3:0]  r_rc, n_rc;
    logic        r_pend, n_pend;
    logic [31:0] r_own_stamp, n_own_stamp;
    lmn_pkg::t_in_item r_item, n_item;
    logic        r_go, n_go;
    logic [1:0]  r_status, n_status;
    logic        r_bcast, n_bcast;
    logic [1:0]  r_mtype, n_mtype;
    logic [NW-1:0] r_nmsg, n_nmsg;
    logic [NW-1:0] r_k, n_k;
    logic [4:0]  r_d, n_d;
    logic        r_out_valid, n_out_valid;
    lmn_pkg::t_out_item r_out, n_out;

    lmn_pkg::t_tbl_op w_op;
    lmn_pkg::t_entry  w_ent [MAX_NODES];
    logic w_cond  [MAX_NODES+1];
    logic w_found [MAX_NODES+1];

    logic       w_full;
    logic       w_granted;
    logic [6:0] w_cnt, w_need, w_n;
    logic       w_own_in;
    logic       w_slot;

    assign w_cond[0]  = 1'b0;
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        lmn_pkg::t_entry w_left, w_right;
        assign w_left  = (g == 0) ? '0 : w_ent[(g == 0) ? 0 : g-1];
        assign w_right = (g == MAX_NODES-1) ? '0 : w_ent[(g == MAX_NODES-1) ? g : g+1];
        lmn_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_left      (w_left),
            .i_left_cond (w_cond[g]),
            .i_right     (w_right),
            .i_found     (w_found[g]),
            .o_cond      (w_cond[g+1]),
            .o_found     (w_found[g+1]),
            .o_entry     (w_ent[g])
        );
    end

    assign w_full   = w_ent[MAX_NODES-1].valid;
    assign w_cnt    = ({2'b0, r_pc} > 7'(MAX_NODES)) ? 7'(MAX_NODES) : {2'b0, r_pc};
    assign w_need   = (w_cnt == 7'd0) ? 7'd0 : w_cnt - 7'd1;
    assign w_own_in = (r_own_id != 5'd0) && ({2'b0, r_own_id} <= w_cnt);
    assign w_n      = ((w_cnt - {6'b0, w_own_in}) > 7'(MAX_NODES-1)) ? 7'(MAX_NODES-1)
                    : (w_cnt - {6'b0, w_own_in});
    assign w_granted = r_pend && w_ent[0].valid && (w_ent[0].node == r_own_id)
                    && ({3'b0, r_rc} >= w_need);
    assign w_slot   = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_op = '0;
        case (r_state)
            ST_REM: begin
                if (r_item.command == lmn_pkg::CMD_RECV_REL) begin
                    w_op = '{ins: 1'b0, rem: 1'b1, node: r_item.sender_id,
                             stamp: r_item.timestamp};
                end else if ((r_item.command == lmn_pkg::CMD_LOCAL_REQ && r_pend) ||
                             (r_item.command == lmn_pkg::CMD_LOCAL_EXIT && w_granted)) begin
                    w_op = '{ins: 1'b0, rem: 1'b1, node: r_own_id, stamp: r_own_stamp};
                end
            end
            ST_UPD: begin
                if (r_item.command == lmn_pkg::CMD_RECV_REQ && !w_full) begin
                    w_op = '{ins: 1'b1, rem: 1'b0, node: r_item.sender_id,
                             stamp: r_item.timestamp};
                end else if (r_item.command == lmn_pkg::CMD_LOCAL_REQ && !w_full) begin
                    w_op = '{ins: 1'b1, rem: 1'b0, node: r_own_id, stamp: r_clock};
                end
            end
            default: w_op = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_own_id    = r_own_id;
        n_pc        = r_pc;
        n_clock     = r_clock;
        n_rc        = r_rc;
        n_pend      = r_pend;
        n_own_stamp = r_own_stamp;
        n_item      = r_item;
        n_go        = r_go;
        n_status    = r_status;
        n_bcast     = r_bcast;
        n_mtype     = r_mtype;
        n_nmsg      = r_nmsg;
        n_k         = r_k;
        n_d         = r_d;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                lmn_pkg::CFG_OWN_ID:      n_own_id = i_cfg_data[4:0];
                lmn_pkg::CFG_PROC_COUNT:  n_pc     = i_cfg_data[4:0];
                lmn_pkg::CFG_START_CLOCK: n_clock  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = ST_REM;
                end
            end
            ST_REM: begin
                n_go    = w_granted;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_status = lmn_pkg::STS_OK;
                n_bcast  = 1'b0;
                n_nmsg   = '0;
                n_k      = '0;
                n_d      = 5'd1;
                case (r_item.command)
                    lmn_pkg::CMD_RECV_REQ: begin
                        if (w_full) begin
                            n_status = lmn_pkg::STS_FULL;
                        end else begin
                            n_clock = (r_clock < r_item.timestamp)
                                    ? lmn_pkg::sat_inc(r_item.timestamp)
                                    : lmn_pkg::sat_inc(r_clock);
                            n_mtype = lmn_pkg::MSG_REPLY;
                            n_nmsg  = NW'(1);
                        end
                    end
                    lmn_pkg::CMD_RECV_REP: begin
                        if (r_rc != lmn_pkg::REPLY_MAX) begin
                            n_rc = r_rc + 4'd1;
                        end
                        n_clock = (r_clock < r_item.timestamp)
                                ? lmn_pkg::sat_inc(r_item.timestamp)
                                : lmn_pkg::sat_inc(r_clock);
                    end
                    lmn_pkg::CMD_TICK: begin
                        n_clock = lmn_pkg::sat_inc(r_clock);
                    end
                    lmn_pkg::CMD_LOCAL_REQ: begin
                        if (w_full) begin
                            n_pend   = 1'b0;
                            n_status = lmn_pkg::STS_FULL;
                        end else begin
                            n_pend      = 1'b1;
                            n_own_stamp = r_clock;
                            n_rc        = '0;
                            n_bcast     = 1'b1;
                            n_mtype     = lmn_pkg::MSG_REQUEST;
                            n_nmsg      = w_n[NW-1:0];
                        end
                    end
                    lmn_pkg::CMD_LOCAL_EXIT: begin
                        if (r_go) begin
                            n_pend  = 1'b0;
                            n_bcast = 1'b1;
                            n_mtype = lmn_pkg::MSG_RELEASE;
                            n_nmsg  = w_n[NW-1:0];
                        end else begin
                            n_status = lmn_pkg::STS_NO_GRANT;
                        end
                    end
                    default: ;
                endcase
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_bcast && r_nmsg != '0 && r_d == r_own_id) begin
                    n_d = r_d + 5'd1;
                end else if (w_slot) begin
                    n_out_valid           = 1'b1;
                    n_out.granted         = w_granted;
                    n_out.clock_now       = r_clock;
                    n_out.replies_seen    = r_rc;
                    n_out.status          = r_status;
                    if (r_nmsg == '0) begin
                        n_out.msg_valid       = 1'b0;
                        n_out.msg_type        = lmn_pkg::MSG_REQUEST;
                        n_out.msg_destination = '0;
                        n_out.msg_timestamp   = '0;
                        n_out.last            = 1'b1;
                        n_state               = ST_IDLE;
                    end else begin
                        n_out.msg_valid       = 1'b1;
                        n_out.msg_type        = r_mtype;
                        n_out.msg_destination = r_bcast ? r_d : r_item.sender_id;
                        n_out.msg_timestamp   = r_bcast ? r_own_stamp : r_clock;
                        n_out.last            = (r_k == r_nmsg - NW'(1));
                        n_k                   = r_k + NW'(1);
                        n_d                   = r_d + 5'd1;
                        if (r_k == r_nmsg - NW'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_own_id    <= lmn_pkg::RST_OWN_ID;
            r_pc        <= lmn_pkg::RST_PCOUNT;
            r_clock     <= lmn_pkg::RST_CLOCK;
            r_rc        <= '0;
            r_pend      <= 1'b0;
            r_own_stamp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_own_id    <= n_own_id;
            r_pc        <= n_pc;
            r_clock     <= n_clock;
            r_rc        <= n_rc;
            r_pend      <= n_pend;
            r_own_stamp <= n_own_stamp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_go     <= n_go;
        r_status <= n_status;
        r_bcast  <= n_bcast;
        r_mtype  <= n_mtype;
        r_nmsg   <= n_nmsg;
        r_k      <= n_k;
        r_d      <= n_d;
        r_out    <= n_out;
    end

endmodule

### design/lmn_cell.sv
module lmn_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmn_pkg::t_tbl_op i_op,
    input  lmn_pkg::t_entry  i_left,
    input  logic            i_left_cond,
    input  lmn_pkg::t_entry  i_right,
    input  logic            i_found,
    output logic            o_cond,
    output logic            o_found,
    output lmn_pkg::t_entry  o_entry
);

    lmn_pkg::t_entry r_ent;
    lmn_pkg::t_entry n_ent;
    logic w_less;
    logic w_match;

    assign w_less  = {i_op.stamp, i_op.node} < {r_ent.stamp, r_ent.node};
    assign o_cond  = !r_ent.valid || w_less;
    assign w_match = r_ent.valid && (r_ent.node == i_op.node) && (r_ent.stamp == i_op.stamp);
    assign o_found = i_found || w_match;
    assign o_entry = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_op.ins) begin
            if (i_left_cond) begin
                n_ent = i_left;
            end else if (o_cond) begin
                n_ent = '{valid: 1'b1, node: i_op.node, stamp: i_op.stamp};
            end
        end else if (i_op.rem && o_found) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else begin
            r_ent <= n_ent;
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int NODES = lmn_pkg::DEF_MAX_NODES;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    lmn_pkg::t_in_item  i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    lmn_pkg::t_out_item o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    lamport_mutex_node #(.MAX_NODES(NODES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // node model state
    logic [4:0]  m_own_id;
    logic [4:0]  m_pcount;
    logic [31:0] m_clock;
    logic [31:0] tbl_stamp [NODES];
    logic [4:0]  tbl_node [NODES];
    int          tbl_used;
    logic [3:0]  m_replies;
    logic        m_pending;
    logic [31:0] m_own_stamp;

    lmn_pkg::t_in_item  pending_items[$];
    lmn_pkg::t_out_item expected_msgs[$];
    int          errors = 0;
    bit          gate_open = 1'b1;
    bit          stim_done = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          n_queued = 0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic merge_clock(input logic [31:0] remote);
        if (m_clock < remote) m_clock = bump(remote);
        else m_clock = bump(m_clock);
    endtask

    function automatic bit tbl_insert(input logic [4:0] node, input logic [31:0] ts);
        int pos;
        if (tbl_used >= NODES) return 1'b0;
        pos = 0;
        while (pos < tbl_used && !(ts < tbl_stamp[pos] ||
               (ts == tbl_stamp[pos] && node < tbl_node[pos])))
            pos++;
        for (int i = tbl_used; i > pos; i--) begin
            tbl_stamp[i] = tbl_stamp[i-1];
            tbl_node[i] = tbl_node[i-1];
        end
        tbl_stamp[pos] = ts;
        tbl_node[pos] = node;
        tbl_used++;
        return 1'b1;
    endfunction

    task automatic tbl_remove(input logic [4:0] node, input logic [31:0] ts);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_node[i] == node && tbl_stamp[i] == ts) begin
                for (int j = i; j + 1 < tbl_used; j++) begin
                    tbl_stamp[j] = tbl_stamp[j+1];
                    tbl_node[j] = tbl_node[j+1];
                end
                tbl_used--;
                return;
            end
        end
    endtask

    function automatic int live_nodes();
        return (m_pcount > NODES) ? NODES : int'(m_pcount);
    endfunction

    function automatic bit have_grant();
        int cnt;
        int need;
        cnt = live_nodes();
        need = (cnt > 0) ? cnt - 1 : 0;
        if (!m_pending || tbl_used == 0) return 1'b0;
        return (int'(m_replies) >= need) && (tbl_node[0] == m_own_id);
    endfunction

    task automatic model_reset();
        m_own_id = lmn_pkg::RST_OWN_ID;
        m_pcount = lmn_pkg::RST_PCOUNT;
        m_clock = lmn_pkg::RST_CLOCK;
        tbl_used = 0;
        m_replies = '0;
        m_pending = 1'b0;
        m_own_stamp = '0;
    endtask

    task automatic predict_node(input lmn_pkg::t_in_item it);
        lmn_pkg::t_out_item msgs[$];
        lmn_pkg::t_out_item r;
        logic [1:0] sts;
        bit bcast;
        logic [1:0] bc_type;
        logic [31:0] bc_ts;
        bit g;
        int nrow;
        sts = lmn_pkg::STS_OK;
        bcast = 1'b0;
        bc_type = lmn_pkg::MSG_REQUEST;
        bc_ts = '0;
        r = '0;
        case (it.command)
            lmn_pkg::CMD_RECV_REQ: begin
                if (tbl_insert(it.sender_id, it.timestamp)) begin
                    merge_clock(it.timestamp);
                    r.msg_valid = 1'b1;
                    r.msg_type = lmn_pkg::MSG_REPLY;
                    r.msg_destination = it.sender_id;
                    r.msg_timestamp = m_clock;
                    msgs.insert(msgs.size(), r);
                end else sts = lmn_pkg::STS_FULL;
            end
            lmn_pkg::CMD_RECV_REP: begin
                if (m_replies != lmn_pkg::REPLY_MAX) m_replies++;
                merge_clock(it.timestamp);
            end
            lmn_pkg::CMD_RECV_REL: tbl_remove(it.sender_id, it.timestamp);
            lmn_pkg::CMD_TICK: m_clock = bump(m_clock);
            lmn_pkg::CMD_LOCAL_REQ: begin
                if (m_pending) tbl_remove(m_own_id, m_own_stamp);
                if (tbl_insert(m_own_id, m_clock)) begin
                    m_pending = 1'b1;
                    m_own_stamp = m_clock;
                    m_replies = '0;
                    bcast = 1'b1;
                    bc_type = lmn_pkg::MSG_REQUEST;
                    bc_ts = m_own_stamp;
                end else begin
                    m_pending = 1'b0;
                    sts = lmn_pkg::STS_FULL;
                end
            end
            lmn_pkg::CMD_LOCAL_EXIT: begin
                if (have_grant()) begin
                    tbl_remove(m_own_id, m_own_stamp);
                    m_pending = 1'b0;
                    bcast = 1'b1;
                    bc_type = lmn_pkg::MSG_RELEASE;
                    bc_ts = m_own_stamp;
                end else sts = lmn_pkg::STS_NO_GRANT;
            end
            default: ;
        endcase
        if (bcast) begin
            for (int d = 1; d <= live_nodes() && msgs.size() < NODES - 1; d++) begin
                if (d != m_own_id) begin
                    r = '0;
                    r.msg_valid = 1'b1;
                    r.msg_type = bc_type;
                    r.msg_destination = d[4:0];
                    r.msg_timestamp = bc_ts;
                    msgs.insert(msgs.size(), r);
                end
            end
        end
        g = have_grant();
        if (msgs.size() == 0) begin
            r = '0;
            msgs.insert(0, r);
        end
        nrow = msgs.size();
        for (int k = 0; k < nrow; k++) begin
            r = msgs[k];
            r.granted = g;
            r.clock_now = m_clock;
            r.replies_seen = m_replies;
            r.status = sts;
            r.last = (k == nrow - 1);
            expected_msgs.insert(expected_msgs.size(), r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_node(i_in);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (gate_open && pending_items.size() > 0) begin
                    i_in <= pending_items[0];
                    pending_items.delete(0);
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= int'($urandom_range(1, 20));
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0
                                  : int'($urandom_range(1, 12));
                    end else burst_left <= burst_left - 1;
                end else i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        lmn_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_msgs.size() == 0) begin
                    $display("%0t unexpected result: actual %h", $time, o_out);
                    errors++;
                end else begin
                    want = expected_msgs[0];
                    expected_msgs.delete(0);
                    if (o_out !== want) begin
                        $display("%0t mismatch: expected %h actual %h", $time, want, o_out);
                        errors++;
                    end
                end
            end
            case ($time / 4000 % 3)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic queue_item(input lmn_pkg::t_in_item it);
        pending_items.insert(pending_items.size(), it);
        n_queued++;
    endtask

    task automatic push_item(input logic [2:0] c, input logic [4:0] s, input logic [31:0] t);
        lmn_pkg::t_in_item it;
        it.command = c;
        it.sender_id = s;
        it.timestamp = t;
        queue_item(it);
    endtask

    task automatic drain_all();
        while (pending_items.size() > 0 || i_in_valid || expected_msgs.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == lmn_pkg::CFG_OWN_ID) m_own_id = val[4:0];
        else if (idx == lmn_pkg::CFG_PROC_COUNT) m_pcount = val[4:0];
        else begin
            m_clock = val;
        end
    endtask

    // one protocol round: peers request, we request, collect replies, a peer releases, exit
    task automatic push_round(input int pc);
        logic [31:0] base;
        base = $urandom_range(0, 50);
        for (int k = 0; k < $urandom_range(0, 3); k++)
            push_item(lmn_pkg::CMD_RECV_REQ, 5'($urandom_range(1, pc)),
                      base + $urandom_range(0, 9));
        push_item(lmn_pkg::CMD_LOCAL_REQ, 5'd0, '0);
        for (int k = 0; k < pc; k++)
            push_item(lmn_pkg::CMD_RECV_REP, 5'($urandom_range(1, pc)),
                      base + $urandom_range(0, 30));
        if ($urandom_range(0, 1)) push_item(lmn_pkg::CMD_TICK, 5'd0, $urandom);
        push_item(lmn_pkg::CMD_RECV_REL, 5'($urandom_range(1, pc)),
                  base + $urandom_range(0, 9));
        push_item(lmn_pkg::CMD_LOCAL_EXIT, 5'd0, '0);
        push_item(lmn_pkg::CMD_LOCAL_EXIT, 5'd0, $urandom);
    endtask

    initial begin
        int pc;
        int start_n;
        bit paused;
        lmn_pkg::t_in_item it;
        paused = 1'b0;
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        push_item(lmn_pkg::CMD_TICK, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_LOCAL_EXIT, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_RECV_REQ, 5'd2, 32'hFFFF_FFFF);
        push_item(lmn_pkg::CMD_TICK, 5'd0, 32'hFFFF_FFFF);
        push_item(lmn_pkg::CMD_RECV_REL, 5'd2, 32'hFFFF_FFFF);
        push_item(lmn_pkg::CMD_RECV_REL, 5'd9, 32'd3);
        push_item(lmn_pkg::CMD_LOCAL_REQ, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_LOCAL_REQ, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_RECV_REP, 5'd2, 32'd0);
        push_item(lmn_pkg::CMD_LOCAL_EXIT, 5'd0, 32'd0);
        push_item(3'd6, 5'd31, 32'h5555_AAAA);
        push_item(3'd7, 5'd16, 32'hAAAA_5555);
        drain_all();

        cfg_write(lmn_pkg::CFG_START_CLOCK, 32'd5);
        cfg_write(lmn_pkg::CFG_OWN_ID, 32'd16);
        cfg_write(lmn_pkg::CFG_PROC_COUNT, 32'd16);
        for (int k = 0; k < 17; k++) push_item(lmn_pkg::CMD_RECV_REQ, k[4:0], 32'd7);
        push_item(lmn_pkg::CMD_LOCAL_REQ, 5'd0, 32'd0);
        for (int k = 0; k < 17; k++) push_item(lmn_pkg::CMD_RECV_REP, 5'd1, 32'd0);
        drain_all();

        cfg_write(lmn_pkg::CFG_PROC_COUNT, 32'd0);
        cfg_write(lmn_pkg::CFG_OWN_ID, 32'd1);
        cfg_write(lmn_pkg::CFG_START_CLOCK, 32'hFFFF_FFFE);
        push_item(lmn_pkg::CMD_LOCAL_REQ, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_LOCAL_EXIT, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_TICK, 5'd0, 32'd0);
        push_item(lmn_pkg::CMD_TICK, 5'd0, 32'd0);
        drain_all();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            pc = (ph == 0) ? 16 : (ph == 1) ? 31 : int'($urandom_range(1, 6));
            cfg_write(lmn_pkg::CFG_PROC_COUNT, 32'(pc[4:0]));
            cfg_write(lmn_pkg::CFG_OWN_ID, (ph == 5) ? 32'd31
                      : 32'($urandom_range(1, (pc > 16) ? 16 : pc)));
            cfg_write(lmn_pkg::CFG_START_CLOCK, (ph == 2) ? 32'hFFFF_FFF0
                      : 32'($urandom_range(0, 20)));
            if (pc > 16) pc = 16;
            start_n = n_queued;
            while (n_queued - start_n < 72) begin
                if ($urandom_range(0, 3) != 0) begin
                    push_round(pc);
                end else begin
                    it = 40'($urandom);
                    if ($urandom_range(0, 1)) it.command = 3'($urandom_range(0, 5));
                    queue_item(it);
                end
                if (ph == 3 && n_queued - start_n > 36 && !paused) begin
                    paused = 1'b1;
                    while (pending_items.size() > 0 || i_in_valid) @(posedge i_clk);
                    gate_open = 1'b0;
                    while (expected_msgs.size() > 0) @(posedge i_clk);
                    gate_open = 1'b1;
                end
            end
            drain_all();
        end

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule
